/* design/bsfd_pkg.sv */
`timescale 1ns / 1ps

package bsfd_pkg;

	localparam logic [7:0] START_CODE_RST  = 8'hFD;
	localparam logic [7:0] STOP_CODE_RST   = 8'hFE;
	localparam logic [7:0] ESCAPE_CODE_RST = 8'hFC;

	localparam logic [8:0] LEN_FIELD_MAX = 9'd511;

	typedef enum logic [1:0] {
		REG_START_CODE  = 2'd0,
		REG_STOP_CODE   = 2'd1,
		REG_ESCAPE_CODE = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_MISSING_START = 3'd1,
		ST_BAD_CHECKSUM  = 3'd2,
		ST_TOO_LONG      = 3'd3,
		ST_DANGLING_ESC  = 3'd4,
		ST_EMPTY         = 3'd5
	} frame_status_t;

	// what the front end made of one received byte
	typedef enum logic [1:0] {
		OP_START = 2'd0,	// start code outside a frame
		OP_JUNK  = 2'd1,	// stray byte outside a frame
		OP_DATA  = 2'd2,	// decoded byte inside a frame
		OP_STOP  = 2'd3	// stop code
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       in_frame;
		logic       esc_pending;
	} op_t;

endpackage

/* design/byte_stuffing_frame_decoder.sv */
`timescale 1ns / 1ps
// A byte that yields a result goes into a queue slot, then the output register, and shows on m_*;
// the held-back data byte leaves when the next decoded byte arrives.
// Throughput: one byte per cycle; an m_* stall fills the queue and drops s_tready.
// Escape bytes and bytes outside a frame, stop codes apart, give no result.
// Reset (arst_n low, asynchronous): codes go to 0xFD/0xFE/0xFC, frame state and queue clear.

module byte_stuffing_frame_decoder
	import bsfd_pkg::*;
#(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,	// in_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,	// out_byte[7:0], frame_status[10:8], frame_length[19:11]
	output logic        m_tuser,	// is_frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic q_full;
	logic q_push;
	op_t  q_op;
	logic q_valid;
	logic q_pop;
	op_t  q_head;

	bsfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	bsfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.full    (q_full),
		.valid   (q_valid),
		.pop     (q_pop),
		.head    (q_head)
	);

	bsfd_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_head   (q_head),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* design/bsfd_front.sv */
`timescale 1ns / 1ps

module bsfd_front
	import bsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	logic [7:0] start_code_q;
	logic [7:0] stop_code_q;
	logic [7:0] escape_code_q;
	logic       in_frame_q;
	logic       esc_pending_q;
	logic       in_frame_n;
	logic       esc_pending_n;
	logic       accept;
	logic       emit;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign q_push    = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q  <= START_CODE_RST;
			stop_code_q   <= STOP_CODE_RST;
			escape_code_q <= ESCAPE_CODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_CODE:  start_code_q  <= cfg_data;
				REG_STOP_CODE:   stop_code_q   <= cfg_data;
				REG_ESCAPE_CODE: escape_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify; stop wins, then start outside / escape inside
	always_comb begin
		emit           = 1'b1;
		in_frame_n     = in_frame_q;
		esc_pending_n  = esc_pending_q;
		q_op.kind        = OP_DATA;
		q_op.data        = s_tdata;
		q_op.in_frame    = in_frame_q;
		q_op.esc_pending = esc_pending_q;
		if (s_tdata == stop_code_q) begin
			q_op.kind     = OP_STOP;
			in_frame_n    = 1'b0;
			esc_pending_n = 1'b0;
		end else if (!in_frame_q) begin
			if (s_tdata == start_code_q) begin
				q_op.kind     = OP_START;
				in_frame_n    = 1'b1;
				esc_pending_n = 1'b0;
			end else begin
				q_op.kind = OP_JUNK;
			end
		end else if (esc_pending_q) begin
			q_op.data     = s_tdata ^ escape_code_q;
			esc_pending_n = 1'b0;
		end else if (s_tdata == escape_code_q) begin
			emit          = 1'b0;
			esc_pending_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			esc_pending_q <= 1'b0;
		end else if (accept) begin
			in_frame_q    <= in_frame_n;
			esc_pending_q <= esc_pending_n;
		end
	end

endmodule

/* design/bsfd_queue.sv */
`timescale 1ns / 1ps

module bsfd_queue
	import bsfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	output logic valid,
	input  logic pop,
	output op_t  head
);

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/bsfd_back.sv */
`timescale 1ns / 1ps

module bsfd_back
	import bsfd_pkg::*;
#(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  op_t         q_head,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,	// out_byte[7:0], frame_status[10:8], frame_length[19:11]
	output logic        m_tuser	// is_frame_end
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int LW = (CW > 9) ? CW : 9;

	logic [CW-1:0] count_q;
	logic [7:0]    sum_q;
	logic [7:0]    held_q;
	logic          held_valid_q;
	logic          overflow_q;
	logic          out_valid_q;
	logic [23:0]   out_data_q;
	logic          out_user_q;

	logic          emit;
	logic [23:0]   res_data;
	logic          res_user;
	logic [LW-1:0] count_ext;
	logic [8:0]    len_sat;
	frame_status_t status;
	logic          at_max;

	assign q_pop     = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign count_ext = LW'(count_q);
	assign len_sat   = (count_ext > LW'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX : count_ext[8:0];
	assign at_max    = (count_q >= CW'(MAX_FRAME));

	always_comb begin
		if (!q_head.in_frame) begin
			status = ST_MISSING_START;
		end else if (overflow_q) begin
			status = ST_TOO_LONG;
		end else if (q_head.esc_pending) begin
			status = ST_DANGLING_ESC;
		end else if (count_q == '0) begin
			status = ST_EMPTY;
		end else if (sum_q != 8'd0) begin
			status = ST_BAD_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		emit     = 1'b0;
		res_user = 1'b0;
		res_data = {16'd0, held_q};
		case (q_head.kind)
			OP_STOP: begin
				emit     = 1'b1;
				res_user = 1'b1;
				res_data = {4'd0, len_sat, status, 8'd0};
			end
			OP_DATA: begin
				emit = held_valid_q && !at_max;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sum_q        <= 8'd0;
			held_valid_q <= 1'b0;
			overflow_q   <= 1'b0;
		end else if (q_pop) begin
			case (q_head.kind)
				OP_START, OP_STOP: begin
					count_q      <= '0;
					sum_q        <= 8'd0;
					held_valid_q <= 1'b0;
					overflow_q   <= 1'b0;
				end
				OP_JUNK: begin
					if (!at_max) begin
						count_q <= count_q + CW'(1);
					end
				end
				OP_DATA: begin
					if (at_max) begin
						overflow_q <= 1'b1;
					end else begin
						held_valid_q <= 1'b1;
						sum_q        <= sum_q + q_head.data;
						count_q      <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == OP_DATA && !at_max) begin
			held_q <= q_head.data;
		end
		if (q_pop && emit) begin
			out_data_q <= res_data;
			out_user_q <= res_user;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= q_pop && emit;
		end
	end

endmodule

/* design/bsfd_checker.sv */
`timescale 1ns / 1ps

module bsfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// data bytes carry no status or length
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
		else $error("data transfer with nonzero status/length");

	// end results carry a legal status and no byte
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[10:8] != 3'd6 && m_tdata[10:8] != 3'd7
			&& m_tdata[7:0] == 8'd0 && m_tdata[23:20] == 4'd0)
		else $error("bad end result");

	// an ok frame holds at least the checksum byte
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[10:8] == 3'd0 |-> m_tdata[19:11] != 9'd0)
		else $error("ok frame with zero length");

endmodule

bind byte_stuffing_frame_decoder bsfd_checker u_bsfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

/* tb/tb_byte_stuffing_frame_decoder.sv */
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_decoder;
	import bsfd_pkg::*;

	localparam int FRAME_LIMIT = 256;
	// index past the register list, the block must ignore it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic          is_end;
		logic [7:0]    data;
		frame_status_t status;
		logic [8:0]    len;
	} deframe_out_t;

	// tracks deframer state and holds the decoded bytes / frame ends still due
	class frame_tracker;
		logic [7:0] start_code = START_CODE_RST;
		logic [7:0] stop_code = STOP_CODE_RST;
		logic [7:0] esc_code = ESCAPE_CODE_RST;
		bit in_frame, esc_pending, held_valid, overflow;
		logic [7:0] held_byte, sum;
		int unsigned count;
		deframe_out_t expected_out[$];
		int errors, n_data;
		int n_end[6];

		function new();
			clear_frame();
		endfunction

		function void clear_frame();
			in_frame = 0;
			esc_pending = 0;
			held_valid = 0;
			overflow = 0;
			held_byte = 8'h00;
			sum = 8'h00;
			count = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%t %s", $realtime, msg);
		endfunction

		function int pending();
			return expected_out.size();
		endfunction

		function void set_code(logic [1:0] idx, logic [7:0] v);
			case (idx)
				REG_START_CODE: start_code = v;
				REG_STOP_CODE: stop_code = v;
				REG_ESCAPE_CODE: esc_code = v;
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0] d;
			deframe_out_t r;
			// stop code wins over every other code match
			if (b == stop_code) begin
				if (!in_frame)
					r.status = ST_MISSING_START;
				else if (overflow)
					r.status = ST_TOO_LONG;
				else if (esc_pending)
					r.status = ST_DANGLING_ESC;
				else if (count == 0)
					r.status = ST_EMPTY;
				else if (sum != 8'h00)
					r.status = ST_BAD_CHECKSUM;
				else
					r.status = ST_OK;
				r.is_end = 1'b1;
				r.data = 8'h00;
				r.len = (count > LEN_FIELD_MAX) ? LEN_FIELD_MAX : 9'(count);
				expected_out.push_back(r);
				clear_frame();
				return;
			end
			if (!in_frame) begin
				if (b == start_code) begin
					clear_frame();
					in_frame = 1;
				end else if (count < FRAME_LIMIT) begin
					count++;
				end
				return;
			end
			if (esc_pending) begin
				esc_pending = 0;
				d = b ^ esc_code;
			end else if (b == esc_code) begin
				esc_pending = 1;
				return;
			end else begin
				d = b;
			end
			if (count >= FRAME_LIMIT) begin
				overflow = 1;
				return;
			end
			// data goes out one byte late so the checksum never leaves
			if (held_valid) begin
				r.is_end = 1'b0;
				r.data = held_byte;
				r.status = ST_OK;
				r.len = 9'd0;
				expected_out.push_back(r);
			end
			held_byte = d;
			held_valid = 1;
			sum += d;
			count++;
		endfunction

		function void check_out(logic user, logic [23:0] word);
			deframe_out_t got;
			deframe_out_t want;
			got.is_end = user;
			got.data = word[7:0];
			got.status = frame_status_t'(word[10:8]);
			got.len = word[19:11];
			if (expected_out.size() == 0) begin
				flag($sformatf("unexpected transfer: end=%0b byte=%02h status=%0d len=%0d",
					got.is_end, got.data, got.status, got.len));
				return;
			end
			want = expected_out.pop_front();
			if (want.is_end)
				n_end[want.status]++;
			else
				n_data++;
			if (got.is_end !== want.is_end || got.data !== want.data ||
					got.status !== want.status || got.len !== want.len)
				flag($sformatf({"mismatch: want end=%0b byte=%02h status=%0d len=%0d, ",
					"got end=%0b byte=%02h status=%0d len=%0d"},
					want.is_end, want.data, want.status, want.len,
					got.is_end, got.data, got.status, got.len));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;	// in_byte[7:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;	// out_byte[7:0], frame_status[10:8], frame_length[19:11]
	logic        m_tuser;	// is_frame_end
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_tracker tr = new();
	int items = 0;
	int burst_left = 1;
	int gap_left = 0;

	// code settings per phase: start, stop, escape
	logic [7:0] ph_start [8] = '{8'hFD, 8'h00, 8'hFF, 8'h55, 8'hA0, 8'h7E, 8'h80, 8'h00};
	logic [7:0] ph_stop  [8] = '{8'hFE, 8'hFF, 8'h01, 8'h55, 8'hB0, 8'hC3, 8'h7F, 8'h00};
	logic [7:0] ph_esc   [8] = '{8'hFC, 8'h01, 8'h00, 8'h55, 8'hA0, 8'hC3, 8'hFF, 8'h00};

	// default codes: bare stop, junk then stop, empty frame, good frame,
	// escapes incl. escaped start/escape, start code as data, stop after escape
	logic [7:0] opening [25] = '{
		STOP_CODE_RST,
		8'h00, 8'hFF, STOP_CODE_RST,
		START_CODE_RST, STOP_CODE_RST,
		START_CODE_RST, 8'h01, 8'hFF, STOP_CODE_RST,
		START_CODE_RST, ESCAPE_CODE_RST, START_CODE_RST, ESCAPE_CODE_RST, ESCAPE_CODE_RST,
		8'h03, STOP_CODE_RST,
		START_CODE_RST, START_CODE_RST, 8'h03, STOP_CODE_RST,
		START_CODE_RST, 8'h10, ESCAPE_CODE_RST, STOP_CODE_RST
	};

	byte_stuffing_frame_decoder #(
		.MAX_FRAME(FRAME_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return tr.start_code;
			1: return tr.stop_code;
			2: return tr.esc_code;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// a decoded byte can be sent if raw is legal or its escaped form is not the stop code
	function automatic bit encodable(logic [7:0] d);
		return (d != tr.stop_code && d != tr.esc_code) || ((d ^ tr.esc_code) != tr.stop_code);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (gap_left > 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		tr.note_byte(b);
		items++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	task automatic send_frame(input int n_dec, input bit good, input bit dangle);
		logic [7:0] d;
		logic [7:0] sum;
		sum = 8'h00;
		send_byte(tr.start_code);
		for (int i = 0; i < n_dec; i++) begin
			if (good && i == n_dec - 1)
				d = -sum;
			else
				d = pick_byte();
			while (!encodable(d))
				d++;
			sum += d;
			if ((d ^ tr.esc_code) != tr.stop_code &&
					(d == tr.stop_code || d == tr.esc_code || $urandom_range(0, 9) == 0)) begin
				send_byte(tr.esc_code);
				send_byte(d ^ tr.esc_code);
			end else begin
				send_byte(d);
			end
		end
		if (dangle)
			send_byte(tr.esc_code);
		send_byte(tr.stop_code);
	endtask

	// hold off the sender until every due transfer has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tr.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_codes(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e,
			input bit stray);
		logic [1:0] idx[$];
		logic [7:0] val[$];
		idx = '{REG_START_CODE, REG_STOP_CODE, REG_ESCAPE_CODE};
		val = '{s, p, e};
		if (stray) begin
			idx.push_back(REG_UNUSED);
			val.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < idx.size(); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			tr.set_code(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int until_items);
		int r;
		while (items < until_items) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame($urandom_range(0, 12), $urandom_range(0, 4) != 0, 1'b0);
			end else if (r < 78) begin
				send_frame($urandom_range(0, 6), 1'b1, 1'b1);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8)) send_byte(pick_byte());
			end else if (r < 95) begin
				// frame left open, the next start code lands as data
				send_byte(tr.start_code);
				repeat ($urandom_range(1, 4)) send_byte(pick_byte());
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				send_byte(tr.stop_code);
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	// receiver: checks each transfer; the stall pattern is picked at random from four modes
	initial begin
		int cyc = 0;
		int mode = 0;
		int hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				tr.check_out(m_tuser, m_tdata);
			cyc++;
			if (cyc % 256 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (cyc % 8) < 3;
				default: begin
					if (hold > 0)
						hold--;
					else if ($urandom_range(0, 9) == 0)
						hold = $urandom_range(1, 12);
					m_tready <= (hold == 0);
				end
			endcase
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START_CODE;
		cfg_data <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_byte(opening[i]);
		// exactly full frame, then one that runs past the limit
		send_frame(FRAME_LIMIT, 1'b1, 1'b0);
		send_frame(FRAME_LIMIT + 2, 1'b1, 1'b0);
		run_random(650);

		for (int p = 1; p < 8; p++) begin
			drain();
			if (p == 7)
				write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b1);
			else
				write_codes(ph_start[p], ph_stop[p], ph_esc[p], 1'b0);
			run_random(650 + 95 * p);
		end
		drain();

		$display("sent %0d bytes under 8 code settings; checked %0d data bytes", items, tr.n_data);
		$display("frame ends: ok %0d, no start %0d, bad sum %0d, too long %0d, open escape %0d, empty %0d",
			tr.n_end[0], tr.n_end[1], tr.n_end[2], tr.n_end[3], tr.n_end[4], tr.n_end[5]);
		if (tr.errors == 0 && tr.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d transfers still due", tr.errors, tr.pending());
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d transfers still due", tr.pending());
		$display("status: fail");
		$finish;
	end

endmodule
